FILE: rtl/core/spq_pkg.sv
package spq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_WIDTH   = 16;
   localparam int KEY_WIDTH   = 16;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_WIDTH   = 5;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_POP    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic                        valid;
      logic signed [KEY_WIDTH-1:0] key;
      logic [TAG_WIDTH-1:0]        tag;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                        insert;
      logic                        pop;
      logic                        remove;
      logic                        clear;
      logic signed [KEY_WIDTH-1:0] key;
      logic [TAG_WIDTH-1:0]        tag;
   } cmd_type;

endpackage

FILE: rtl/core/stable_sorted_priority_queue.sv
// Sorted priority queue of QUEUE_DEPTH entries (signed Q8.8 key plus tag).
// Command channel: a word is taken at a rising edge with start high and
// busy low; busy stays low, so a command may be issued every cycle.
// req_mode picks insert, pop head, remove by tag, or clear.
// Result channel: exactly one result per command, shown on the rsp_ ports
// for one cycle with rsp_valid high, in the cycle after the command edge
// (throughput 1 command per cycle).
// The receiver cannot stall; results must be taken when rsp_valid is high.
// Storage is a row of cells, one entry each. On insert every cell compares
// its key with the new one in parallel and the greater ones shift toward
// the tail by one; on pop or remove the cells from the hit position onward
// take their right neighbor. Equal keys keep arrival order.
// Errors (pop of empty queue, insert into full queue, tag not found)
// leave the contents unchanged and report key and tag of zero.
// Reset (synchronous, active high) empties the queue; entry
// payload is not cleared, only the valid flags and the count.
module stable_sorted_priority_queue
   import spq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_mode,
   input  logic signed [KEY_WIDTH-1:0] req_key_in,
   input  logic [15:0]                 req_tag_in,
   output logic                        rsp_valid,
   output logic signed [KEY_WIDTH-1:0] rsp_key_out,
   output logic [15:0]                 rsp_tag_out,
   output logic [1:0]                  rsp_status,
   output logic [OCC_WIDTH-1:0]        rsp_occupancy
);

   mode_type  mode;
   cmd_type   cmd;
   logic      accept;
   logic      full;
   logic      any_found;

   entry_type cell_entry [QUEUE_DEPTH];
   logic      cell_gt    [QUEUE_DEPTH];
   logic      cell_found [QUEUE_DEPTH];
   logic      cell_hit   [QUEUE_DEPTH];

   logic [COUNT_WIDTH-1:0]      count_ff;
   logic [COUNT_WIDTH-1:0]      count_in;
   logic                        rsp_valid_ff;
   logic signed [KEY_WIDTH-1:0] key_out_ff;
   logic signed [KEY_WIDTH-1:0] key_out_in;
   logic [TAG_WIDTH-1:0]        tag_out_ff;
   logic [TAG_WIDTH-1:0]        tag_out_in;
   status_type                  status_ff;
   status_type                  status_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign mode   = mode_type'(req_mode);
   assign full   = cell_entry[QUEUE_DEPTH-1].valid;

   always_comb begin
      cmd        = '0;
      cmd.key    = req_key_in;
      cmd.tag    = TAG_WIDTH'(req_tag_in);
      if (accept) begin
         unique case (mode)
            MODE_INSERT: cmd.insert = !full;
            MODE_POP:    cmd.pop    = 1'b1;
            MODE_REMOVE: cmd.remove = 1'b1;
            MODE_CLEAR:  cmd.clear  = 1'b1;
            default:     cmd.clear  = 1'b0;
         endcase
      end
   end

   // row of cells, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_gt;
      entry_type right_entry;
      logic      found_in;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_gt    = 1'b0;
         assign found_in   = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_gt    = cell_gt[i-1];
         assign found_in   = cell_found[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .found_in    (found_in),
         .entry       (cell_entry[i]),
         .gt          (cell_gt[i]),
         .found_out   (cell_found[i]),
         .hit         (cell_hit[i])
      );
   end

   assign any_found = cell_found[QUEUE_DEPTH-1];

   // at most one cell hits, so an or of masked entries selects it
   always_comb begin
      key_out_in = '0;
      tag_out_in = '0;
      if (cmd.pop || cmd.remove) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (cell_hit[i]) begin
               key_out_in = key_out_in | cell_entry[i].key;
               tag_out_in = tag_out_in | cell_entry[i].tag;
            end
         end
      end
   end

   always_comb begin
      status_in = STATUS_OK;
      count_in  = count_ff;
      unique case (mode)
         MODE_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
         end
         MODE_POP: begin
            if (!any_found) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         MODE_REMOVE: begin
            if (!any_found) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      if (accept) begin
         key_out_ff <= key_out_in;
         tag_out_ff <= tag_out_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_out   = key_out_ff;
   assign rsp_tag_out   = 16'(tag_out_ff);
   assign rsp_status    = status_ff;
   assign rsp_occupancy = OCC_WIDTH'(count_ff);

endmodule

FILE: rtl/core/spq_cell.sv
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  entry_type left_entry,
   input  logic      left_gt,
   input  entry_type right_entry,
   input  logic      found_in,
   output entry_type entry,
   output logic      gt,
   output logic      found_out,
   output logic      hit
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;

   assign entry = entry_ff;

   // empty slots count as greater so the new word lands at the tail
   assign gt = !entry_ff.valid || (entry_ff.key > cmd.key);

   assign match     = entry_ff.valid && (cmd.pop || (entry_ff.tag == cmd.tag));
   assign found_out = found_in || match;
   assign hit       = match && !found_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.clear) begin
         entry_in.valid = 1'b0;
      end else if (cmd.insert) begin
         if (gt) begin
            if (left_gt) begin
               entry_in = left_entry;
            end else begin
               entry_in.valid = 1'b1;
               entry_in.key   = cmd.key;
               entry_in.tag   = cmd.tag;
            end
         end
      end else if ((cmd.pop || cmd.remove) && found_out) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.key <= entry_in.key;
      entry_ff.tag <= entry_in.tag;
   end

endmodule
